// ===== rtl/core/ipv4s_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4s_pkg
// Shared constants and types for the descending address sorter.
// ----------------------------------------------------------------------------
package ipv4s_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/core/ipv4s_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4s_in_if / ipv4s_out_if
// Valid/ready channels for address items and sorted result items.
// ----------------------------------------------------------------------------
interface ipv4s_in_if;
  logic                   valid;
  logic                   ready;
  ipv4s_pkg::addr_t       address;
  logic                   last;

  modport source (output valid, output address, output last, input ready);
  modport sink   (input valid, input address, input last, output ready);
endinterface

interface ipv4s_out_if;
  logic                   valid;
  logic                   ready;
  ipv4s_pkg::addr_t       sorted_address;
  logic                   last_res;
  logic                   overflow;

  modport source (output valid, output sorted_address, output last_res,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_address, input last_res,
                  input overflow, output ready);
endinterface

// ===== rtl/core/ipv4s_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4s_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ipv4s_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/ipv4_address_descending_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_address_descending_sorter
// Collects a set of IPv4 addresses and returns them in descending order.
// ----------------------------------------------------------------------------
// Addresses are loaded one item per cycle into a 64-entry store until the
// item marked last arrives; addresses beyond the store's capacity are dropped
// and every result of that set then carries overflow. After the last item the
// block does a selection sort in place: each pass reads the remaining entries
// through the store's single read port into one 32-bit comparator, emits the
// largest and moves the pass's first entry into the freed slot. Each pass
// scans from its first entry to the last stored one, then a drain state takes
// the final read before the result is offered. No item is taken until the last
// result is delivered. The store needs no clearing after reset.
module ipv4_address_descending_sorter (
  input  logic              clk,
  input  logic              rst_n,
  ipv4s_in_if.sink          in_ch,
  ipv4s_out_if.source       out_ch
);
  import ipv4s_pkg::*;

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   drop_r, drop_nxt;
  idx_t   p_r, p_nxt;          // first slot of the unsorted region
  idx_t   rd_idx_r, rd_idx_nxt;
  logic   pend_v_r, pend_v_nxt;
  idx_t   pend_idx_r, pend_idx_nxt;
  addr_t  best_r, best_nxt;
  idx_t   best_idx_r, best_idx_nxt;
  addr_t  first_r, first_nxt;

  logic   ram_we;
  idx_t   ram_wr_addr;
  addr_t  ram_wr_data;
  addr_t  ram_rd_data;

  logic   in_acc, out_acc, scan_end, emit_last, has_room;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_acc   = out_ch.valid && out_ch.ready;
  assign scan_end  = CNT_W'(rd_idx_r) == (cnt_r - CNT_W'(1));
  assign emit_last = CNT_W'(p_r) == (cnt_r - CNT_W'(1));
  assign has_room  = cnt_r < CNT_W'(CAPACITY);

  ipv4s_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (rd_idx_r),
    .rd_data (ram_rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_ch.last) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc) state_nxt = emit_last ? ST_LOAD : ST_SCAN;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready           = (state_r == ST_LOAD);
    out_ch.valid          = (state_r == ST_EMIT);
    out_ch.sorted_address = best_r;
    out_ch.last_res       = emit_last;
    out_ch.overflow       = drop_r;
    ram_we                = 1'b0;
    ram_wr_addr           = best_idx_r;
    ram_wr_data           = first_r;
    if (state_r == ST_LOAD) begin
      ram_we      = in_acc && has_room;
      ram_wr_addr = idx_t'(cnt_r);
      ram_wr_data = in_ch.address;
    end else if (state_r == ST_EMIT) begin
      // the emitted slot takes the pass's first entry
      ram_we = out_acc;
    end
  end

  // datapath
  always_comb begin
    cnt_nxt      = cnt_r;
    drop_nxt     = drop_r;
    p_nxt        = p_r;
    rd_idx_nxt   = rd_idx_r;
    pend_v_nxt   = (state_r == ST_SCAN);
    pend_idx_nxt = rd_idx_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    first_nxt    = first_r;

    if (pend_v_r) begin
      if (pend_idx_r == p_r) begin
        first_nxt    = ram_rd_data;
        best_nxt     = ram_rd_data;
        best_idx_nxt = pend_idx_r;
      end else if (ram_rd_data > best_r) begin
        best_nxt     = ram_rd_data;
        best_idx_nxt = pend_idx_r;
      end
    end

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (has_room) cnt_nxt = cnt_r + CNT_W'(1);
          else          drop_nxt = 1'b1;
          p_nxt      = '0;
          rd_idx_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (!scan_end) rd_idx_nxt = rd_idx_r + idx_t'(1);
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (emit_last) begin
            cnt_nxt  = '0;
            drop_nxt = 1'b0;
          end else begin
            p_nxt      = p_r + idx_t'(1);
            rd_idx_nxt = p_r + idx_t'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      cnt_r    <= '0;
      drop_r   <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      drop_r   <= drop_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    first_r    <= first_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_drop_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !has_room) |=> drop_r)
    else $error("full store did not flag a dropped address");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("read data pending outside a scan");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (CNT_W'(p_r) < cnt_r))
    else $error("emitting past the stored entries");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && emit_last) |=> (cnt_r == '0 && !drop_r && state_r == ST_LOAD))
    else $error("set not cleared after its final result");

endmodule
